>>> hdl/audio_bucket_peak_rms_assert.svh
// Assertion macros shared by the audio bucket peak and RMS design.
`ifndef AUDIO_BUCKET_PEAK_RMS_ASSERT_SVH
`define AUDIO_BUCKET_PEAK_RMS_ASSERT_SVH
`ifndef ASSERT_OFF
`define ABP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ABP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ABP_ASSERT_IMP(lbl, ante, cons)
`define ABP_ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> hdl/abp_pkg.sv
// Types and constants of the audio bucket peak and RMS block.
`timescale 1ns / 1ps
package abp_pkg;
  localparam int unsigned MAX_BUCKETS_DEF = 1024;
  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [10:0] BCOUNT_RST = 11'd1024;
  localparam logic [18:0] DRATE_RST = 19'd48000;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_READ,
    KIND_CLEAR
  } kind_t;

  typedef enum logic [1:0] {
    REG_WSTART = 2'd0,
    REG_WEND   = 2'd1,
    REG_BCOUNT = 2'd2,
    REG_DRATE  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_TSTART,
    ST_TDIV,
    ST_TCHK,
    ST_IDX,
    ST_FETCH,
    ST_UPDATE,
    ST_RCHK,
    ST_RDATA,
    ST_RDIV,
    ST_SQRT,
    ST_OUT
  } bk_state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample;
    logic [47:0]        frame_start;
    logic [15:0]        position;
    logic [18:0]        rate;
    logic [9:0]         bucket;
  } abp_entry_t;

  typedef struct packed {
    logic signed [15:0] mn;
    logic [14:0]        mx;
    logic [63:0]        sumsq;
    logic [39:0]        cnt;
  } abp_word_t;

  typedef struct packed {
    logic init_busy;
  } abp_status_t;
endpackage

>>> hdl/abp_front.sv
// Input side: takes beats, decodes the command and queues work for the back end.
`timescale 1ns / 1ps
module abp_front (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [111:0]         in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic [18:0]          default_rate,
  input  abp_pkg::abp_status_t status,
  input  logic                 q_full,
  output logic                 q_push,
  output abp_pkg::abp_entry_t  q_entry
);
  logic [18:0] rate_sel;
  logic        keep;

  assign in_tready = !q_full && !status.init_busy;
  assign rate_sel  = (in_tdata[98:80] != 19'd0) ? in_tdata[98:80] : default_rate;

  always_comb begin
    q_entry.sample      = $signed(in_tdata[15:0]);
    q_entry.frame_start = in_tdata[63:16];
    q_entry.position    = in_tdata[79:64];
    q_entry.rate        = rate_sel;
    q_entry.bucket      = in_tdata[108:99];
    q_entry.kind        = abp_pkg::KIND_ADD;
    keep                = 1'b0;
    unique case (abp_pkg::cmd_t'(in_tuser))
      abp_pkg::CMD_ADD: begin
        // A sample with no usable rate can never land in a bucket.
        keep = (rate_sel != 19'd0);
      end
      abp_pkg::CMD_READ: begin
        q_entry.kind = abp_pkg::KIND_READ;
        keep         = 1'b1;
      end
      abp_pkg::CMD_CLEAR: begin
        q_entry.kind = abp_pkg::KIND_CLEAR;
        keep         = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_tvalid && in_tready && keep;
endmodule

>>> hdl/abp_fifo.sv
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module abp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  abp_pkg::abp_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output abp_pkg::abp_entry_t pop_data
);
  abp_pkg::abp_entry_t slot_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          fill_r;

  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end
endmodule

>>> hdl/abp_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module abp_div #(
  parameter int unsigned N_W = 64,
  parameter int unsigned D_W = 40
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);
  localparam int unsigned CW = $clog2(N_W + 1);

  logic [N_W-1:0] qd_r;
  logic [D_W-1:0] rem_r;
  logic [D_W-1:0] div_r;
  logic [CW-1:0]  cnt_r;
  logic           run_r;
  logic           done_r;
  logic [D_W:0]   rem_sh;
  logic [D_W:0]   diff;
  logic           ge;

  assign rem_sh   = {rem_r, qd_r[N_W-1]};
  assign diff     = rem_sh - {1'b0, div_r};
  assign ge       = (rem_sh >= {1'b0, div_r});
  assign done     = done_r;
  assign quotient = qd_r;

  always_ff @(posedge clk) begin
    if (start) begin
      qd_r  <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      qd_r  <= {qd_r[N_W-2:0], ge};
      rem_r <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(N_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

>>> hdl/abp_back.sv
// Back end: time and bucket arithmetic, statistics store, read-out with RMS.
`timescale 1ns / 1ps
module abp_back #(
  parameter int unsigned MAX_BUCKETS = abp_pkg::MAX_BUCKETS_DEF,
  parameter int unsigned AW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1,
  parameter int unsigned BCW = $clog2(MAX_BUCKETS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  abp_pkg::abp_entry_t  q_entry,
  output logic                 q_pop,
  input  logic [47:0]          win_start,
  input  logic [47:0]          win_end,
  input  logic [BCW-1:0]       bc_eff,
  output abp_pkg::abp_status_t status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [87:0]          out_tdata,
  output logic [0:0]           out_tuser
);
  localparam int unsigned CW = $clog2(BCW + 1);

  abp_pkg::bk_state_t  state_r, state_nxt;
  abp_pkg::abp_entry_t ent_r;
  abp_pkg::abp_word_t  mem [MAX_BUCKETS];
  abp_pkg::abp_word_t  rd_data_r;
  abp_pkg::abp_word_t  wr_word;
  abp_pkg::abp_word_t  upd_word;

  logic [AW-1:0]  clr_addr_r;
  logic           init_r;
  logic           seen_r;
  logic [45:0]    prod_r;
  logic [48:0]    t_r;
  logic [47:0]    d_r;
  logic [47:0]    span_r;
  logic [30:0]    sq_r;
  logic [49:0]    r_r;
  logic [BCW-1:0] q_r;
  logic [BCW-1:0] n_r;
  logic [CW-1:0]  bcnt_r;
  logic           phase_r;
  logic [AW-1:0]  idx_r;
  logic [63:0]    v_r;
  logic [31:0]    root_r;
  logic [34:0]    srem_r;
  logic [5:0]     scnt_r;
  logic signed [15:0] res_min_r;
  logic [14:0]    res_max_r;
  logic [39:0]    res_cnt_r;
  logic           out_valid_r;
  logic [87:0]    out_data_r;
  logic           out_any_r;

  // Control decoded from the state.
  logic           div_start;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic           out_load;

  logic [63:0]    div_dvd;
  logic [39:0]    div_dsr;
  logic           div_done;
  logic [63:0]    div_q;

  logic           bucket_oob;
  logic           time_out;
  logic           add_void;
  logic [49:0]    r_sh;
  logic [49:0]    r_add;
  logic           sh_ge;
  logic           add_ge;
  logic [BCW-1:0] q_step;
  logic [34:0]    srem_sh;
  logic [34:0]    trial;
  logic           s_ge;
  logic signed [31:0] sq_full;
  logic [64:0]    sum_ext;
  logic [15:0]    rms_val;

  assign status.init_busy = init_r;
  assign bucket_oob = (32'(ent_r.bucket) >= 32'(MAX_BUCKETS));
  assign time_out   = (t_r < {1'b0, win_start}) || (t_r >= {1'b0, win_end});
  assign add_void   = (bc_eff == '0) || (win_end <= win_start);

  assign r_sh   = {r_r[48:0], 1'b0};
  assign sh_ge  = (r_sh >= {2'b00, span_r});
  assign r_add  = r_r + {2'b00, d_r};
  assign add_ge = (r_add >= {2'b00, span_r});
  assign q_step = (q_r << 1) | BCW'(sh_ge);

  assign srem_sh = {srem_r[32:0], v_r[63:62]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign s_ge    = (srem_sh >= trial);

  assign sq_full = $signed({{16{ent_r.sample[15]}}, ent_r.sample})
                 * $signed({{16{ent_r.sample[15]}}, ent_r.sample});
  assign sum_ext = {1'b0, rd_data_r.sumsq} + {34'd0, sq_r};
  assign rms_val = (root_r > 32'd32768) ? 16'h8000 : root_r[15:0];

  always_comb begin
    upd_word.mn = (ent_r.sample < rd_data_r.mn) ? ent_r.sample : rd_data_r.mn;
    upd_word.mx = ($signed({1'b0, rd_data_r.mx}) < ent_r.sample) ?
                  ent_r.sample[14:0] : rd_data_r.mx;
    upd_word.sumsq = sum_ext[64] ? '1 : sum_ext[63:0];
    upd_word.cnt   = (rd_data_r.cnt == '1) ? rd_data_r.cnt : rd_data_r.cnt + 40'd1;
  end

  assign div_dvd = (state_r == abp_pkg::ST_TSTART) ? {18'd0, prod_r} : rd_data_r.sumsq;
  assign div_dsr = (state_r == abp_pkg::ST_TSTART) ? {21'd0, ent_r.rate} : rd_data_r.cnt;

  abp_div #(.N_W(64), .D_W(40)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      abp_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(MAX_BUCKETS - 1)) state_nxt = abp_pkg::ST_IDLE;
      end
      abp_pkg::ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_entry.kind)
            abp_pkg::KIND_ADD:  state_nxt = abp_pkg::ST_MUL;
            abp_pkg::KIND_READ: state_nxt = abp_pkg::ST_RCHK;
            default:            state_nxt = abp_pkg::ST_CLEAR;
          endcase
        end
      end
      abp_pkg::ST_MUL:    state_nxt = add_void ? abp_pkg::ST_IDLE : abp_pkg::ST_TSTART;
      abp_pkg::ST_TSTART: state_nxt = abp_pkg::ST_TDIV;
      abp_pkg::ST_TDIV: begin
        if (div_done) state_nxt = abp_pkg::ST_TCHK;
      end
      abp_pkg::ST_TCHK:   state_nxt = time_out ? abp_pkg::ST_IDLE : abp_pkg::ST_IDX;
      abp_pkg::ST_IDX: begin
        if (phase_r && bcnt_r == CW'(1)) begin
          state_nxt = abp_pkg::ST_FETCH;
        end
      end
      abp_pkg::ST_FETCH: begin
        state_nxt = (q_r < bc_eff) ? abp_pkg::ST_UPDATE : abp_pkg::ST_IDLE;
      end
      abp_pkg::ST_UPDATE: state_nxt = abp_pkg::ST_IDLE;
      abp_pkg::ST_RCHK:   state_nxt = bucket_oob ? abp_pkg::ST_OUT : abp_pkg::ST_RDATA;
      abp_pkg::ST_RDATA: begin
        state_nxt = (rd_data_r.cnt == '0) ? abp_pkg::ST_OUT : abp_pkg::ST_RDIV;
      end
      abp_pkg::ST_RDIV: begin
        if (div_done) state_nxt = abp_pkg::ST_SQRT;
      end
      abp_pkg::ST_SQRT: begin
        if (scnt_r == 6'd1) state_nxt = abp_pkg::ST_OUT;
      end
      abp_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = abp_pkg::ST_IDLE;
      end
      default: state_nxt = abp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    wr_word   = upd_word;
    mem_re    = 1'b0;
    mem_raddr = idx_r;
    out_load  = 1'b0;
    unique case (state_r)
      abp_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        wr_word   = '0;
      end
      abp_pkg::ST_IDLE:   q_pop = !q_empty;
      abp_pkg::ST_TSTART: div_start = 1'b1;
      abp_pkg::ST_FETCH: begin
        // The bucket index is only in q_r here; idx_r takes it at this edge.
        mem_re    = 1'b1;
        mem_raddr = AW'(q_r);
      end
      abp_pkg::ST_UPDATE: mem_we = 1'b1;
      abp_pkg::ST_RCHK: begin
        mem_re    = !bucket_oob;
        mem_raddr = AW'(ent_r.bucket);
      end
      abp_pkg::ST_RDATA:  div_start = (rd_data_r.cnt != '0);
      abp_pkg::ST_OUT:    out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wr_word;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_entry;
    end
    unique case (state_r)
      abp_pkg::ST_MUL: prod_r <= 46'(ent_r.position) * 46'(abp_pkg::NS_PER_S);
      abp_pkg::ST_TDIV: begin
        if (div_done) t_r <= {1'b0, ent_r.frame_start} + div_q[48:0];
      end
      abp_pkg::ST_TCHK: begin
        d_r     <= t_r[47:0] - win_start;
        span_r  <= win_end - win_start;
        r_r     <= '0;
        q_r     <= '0;
        n_r     <= bc_eff;
        bcnt_r  <= CW'(BCW);
        phase_r <= 1'b0;
      end
      abp_pkg::ST_IDX: begin
        // Long division of d * bucket_count by span, one multiplier bit per shift phase and add phase.
        if (!phase_r) begin
          q_r <= q_step;
          r_r <= sh_ge ? (r_sh - {2'b00, span_r}) : r_sh;
        end else begin
          if (n_r[BCW-1]) begin
            q_r <= q_r + BCW'(add_ge);
            r_r <= add_ge ? (r_add - {2'b00, span_r}) : r_add;
          end
          n_r    <= n_r << 1;
          bcnt_r <= bcnt_r - CW'(1);
        end
        phase_r <= !phase_r;
      end
      abp_pkg::ST_FETCH: begin
        idx_r <= AW'(q_r);
        sq_r  <= sq_full[30:0];
      end
      abp_pkg::ST_RCHK: begin
        res_min_r <= '0;
        res_max_r <= '0;
        res_cnt_r <= '0;
        root_r    <= '0;
      end
      abp_pkg::ST_RDATA: begin
        res_min_r <= rd_data_r.mn;
        res_max_r <= rd_data_r.mx;
        res_cnt_r <= rd_data_r.cnt;
      end
      abp_pkg::ST_RDIV: begin
        if (div_done) begin
          v_r    <= div_q;
          root_r <= '0;
          srem_r <= '0;
          scnt_r <= 6'd32;
        end
      end
      abp_pkg::ST_SQRT: begin
        srem_r <= s_ge ? (srem_sh - trial) : srem_sh;
        root_r <= {root_r[30:0], s_ge};
        v_r    <= v_r << 2;
        scnt_r <= scnt_r - 6'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= {1'b0, res_cnt_r, rms_val, res_max_r, res_min_r};
      out_any_r  <= seen_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abp_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      init_r      <= 1'b1;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == abp_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_BUCKETS - 1)) begin
          clr_addr_r <= '0;
          init_r     <= 1'b0;
        end
      end
      if (q_pop && q_entry.kind == abp_pkg::KIND_CLEAR) begin
        seen_r <= 1'b0;
      end else if (state_r == abp_pkg::ST_UPDATE) begin
        seen_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_any_r;
endmodule

>>> hdl/audio_bucket_peak_rms.sv
// Add: the time offset comes from the 64-step divider, then a bitwise long division finds the bucket.
// Read: 64 divider steps for sumsq/count plus 32 square-root steps.
// Clear: the store is swept to zero, one store entry written per cycle.
// The two-deep queue takes new beats while the back end works on one item at a time.
// After reset the store is swept to zero; in_tready stays low then.
// Reset: synchronous, active low; control and config registers reset, datapath registers do not.
`timescale 1ns / 1ps
`include "audio_bucket_peak_rms_assert.svh"
module audio_bucket_peak_rms #(
  parameter int unsigned MAX_BUCKETS = abp_pkg::MAX_BUCKETS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sample_value, frame_start_ns, frame_position, frame_rate_hz, read_bucket
  input  logic [111:0] in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // bucket_min, bucket_max, bucket_rms, bucket_samples
  output logic [87:0]  out_tdata,
  // any_samples
  output logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int unsigned AW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned BCW = $clog2(MAX_BUCKETS + 1);

  logic [47:0] win_start_r;
  logic [47:0] win_end_r;
  logic [10:0] bcount_r;
  logic [18:0] drate_r;
  logic [BCW-1:0] bc_eff;
  abp_pkg::reg_idx_t reg_idx;

  abp_pkg::abp_status_t bk_status;
  abp_pkg::abp_entry_t  push_entry;
  abp_pkg::abp_entry_t  pop_entry;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  assign cfg_pready = 1'b1;
  assign reg_idx    = abp_pkg::reg_idx_t'(cfg_paddr[4:3]);
  assign bc_eff     = (32'(bcount_r) > 32'(MAX_BUCKETS)) ? BCW'(MAX_BUCKETS) : BCW'(bcount_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      win_end_r   <= '0;
      bcount_r    <= abp_pkg::BCOUNT_RST;
      drate_r     <= abp_pkg::DRATE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (reg_idx)
        abp_pkg::REG_WSTART: win_start_r <= cfg_pwdata[47:0];
        abp_pkg::REG_WEND:   win_end_r   <= cfg_pwdata[47:0];
        abp_pkg::REG_BCOUNT: bcount_r    <= cfg_pwdata[10:0];
        default:             drate_r     <= cfg_pwdata[18:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      abp_pkg::REG_WSTART: cfg_prdata = {16'd0, win_start_r};
      abp_pkg::REG_WEND:   cfg_prdata = {16'd0, win_end_r};
      abp_pkg::REG_BCOUNT: cfg_prdata = {53'd0, bcount_r};
      default:             cfg_prdata = {45'd0, drate_r};
    endcase
  end

  abp_front u_front (
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .default_rate (drate_r),
    .status       (bk_status),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  abp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (pop_entry)
  );

  abp_back #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .AW          (AW),
    .BCW         (BCW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .win_start  (win_start_r),
    .win_end    (win_end_r),
    .bc_eff     (bc_eff),
    .status     (bk_status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `ABP_ASSERT_IMP(a_no_accept_in_init, bk_status.init_busy, !in_tready)
  `ABP_ASSERT_NEVER(a_queue_overflow, q_push && q_full)
  `ABP_ASSERT_NEVER(a_queue_underflow, q_pop && q_empty)
  `ABP_ASSERT_IMP(a_rms_limit, out_tvalid, out_tdata[46:31] <= 16'd32768)
endmodule

>>> tb/tb.sv
// Self-checking testbench for the audio bucket peak and RMS block.
`timescale 1ns / 1ps
module tb;
  localparam int unsigned NBKT = abp_pkg::MAX_BUCKETS_DEF;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  // Covers a clear in the back end plus two more clears waiting in the queue.
  localparam int unsigned DRAIN_CYCLES = 3500;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [15:0] mn;
    logic [14:0] mx;
    logic [15:0] rms;
    logic [39:0] cnt;
    logic        any;
  } bucket_report_t;

  class bucket_stats_board;
    logic signed [15:0] lo_q[NBKT];
    logic signed [15:0] hi_q[NBKT];
    logic [63:0] sq_sum[NBKT];
    logic [39:0] n_q[NBKT];
    logic        seen;
    logic [47:0] win_lo, win_hi;
    logic [10:0] nbuckets;
    logic [18:0] dflt_rate;
    bucket_report_t reports[$];
    int errors;

    function void wipe();
      for (int i = 0; i < NBKT; i++) begin
        lo_q[i] = '0;
        hi_q[i] = '0;
        sq_sum[i] = '0;
        n_q[i] = '0;
      end
      seen = 0;
    endfunction

    function void power_on();
      wipe();
      win_lo = '0;
      win_hi = '0;
      nbuckets = abp_pkg::BCOUNT_RST;
      dflt_rate = abp_pkg::DRATE_RST;
      errors = 0;
    endfunction

    function void set_reg(abp_pkg::reg_idx_t r, logic [63:0] v);
      case (r)
        abp_pkg::REG_WSTART: win_lo = v[47:0];
        abp_pkg::REG_WEND: win_hi = v[47:0];
        abp_pkg::REG_BCOUNT: nbuckets = v[10:0];
        abp_pkg::REG_DRATE: dflt_rate = v[18:0];
      endcase
    endfunction

    function logic [15:0] floor_root(logic [63:0] v);
      logic [127:0] trial;
      logic [31:0] root;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = {96'd0, root | (32'd1 << b)};
        if (trial * trial <= {64'd0, v}) root = trial[31:0];
      end
      return (root > 32768) ? 16'd32768 : root[15:0];
    endfunction

    function void accept(abp_pkg::cmd_t c, logic signed [15:0] s, logic [47:0] fs,
                         logic [15:0] pos, logic [18:0] rt, logic [9:0] bk);
      logic [63:0] rate, bc, t, span, idx, sq;
      logic [64:0] wide;
      bucket_report_t r;
      case (c)
        abp_pkg::CMD_CLEAR: wipe();
        abp_pkg::CMD_READ: begin
          r.mn = lo_q[bk];
          r.mx = hi_q[bk][14:0];
          r.cnt = n_q[bk];
          r.rms = (n_q[bk] == 0) ? 16'd0 : floor_root(sq_sum[bk] / n_q[bk]);
          r.any = seen;
          reports.push_back(r);
        end
        abp_pkg::CMD_ADD: begin
          rate = (rt != 0) ? rt : dflt_rate;
          bc = (nbuckets > NBKT) ? NBKT : nbuckets;
          if (rate == 0 || bc == 0 || win_hi <= win_lo) return;
          t = fs + (pos * 64'd1000000000) / rate;
          if (t < win_lo || t >= win_hi) return;
          span = win_hi - win_lo;
          idx = ((t - win_lo) * bc) / span;
          if (idx >= bc) return;
          if (s < lo_q[idx]) lo_q[idx] = s;
          if (s > hi_q[idx]) hi_q[idx] = s;
          sq = 64'(longint'(s) * longint'(s));
          wide = {1'b0, sq_sum[idx]} + {1'b0, sq};
          sq_sum[idx] = wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
          if (n_q[idx] != 40'hFF_FFFF_FFFF) n_q[idx]++;
          seen = 1;
        end
        default: ;
      endcase
    endfunction

    function void check(bucket_report_t got);
      bucket_report_t e;
      if (reports.size() == 0) begin
        $display("%0t: unexpected beat min=%0d max=%0d rms=%0d cnt=%0d any=%0d", $time,
                 $signed(got.mn), got.mx, got.rms, got.cnt, got.any);
        errors++;
        return;
      end
      e = reports.pop_front();
      if (got.mn !== e.mn) begin
        $display("%0t: bucket_min exp %0d got %0d", $time, $signed(e.mn), $signed(got.mn));
        errors++;
      end
      if (got.mx !== e.mx) begin
        $display("%0t: bucket_max exp %0d got %0d", $time, e.mx, got.mx);
        errors++;
      end
      if (got.rms !== e.rms) begin
        $display("%0t: bucket_rms exp %0d got %0d", $time, e.rms, got.rms);
        errors++;
      end
      if (got.cnt !== e.cnt) begin
        $display("%0t: bucket_samples exp %0d got %0d", $time, e.cnt, got.cnt);
        errors++;
      end
      if (got.any !== e.any) begin
        $display("%0t: any_samples exp %0d got %0d", $time, e.any, got.any);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [87:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [4:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  audio_bucket_peak_rms dut (.*);

  bucket_stats_board board = new();
  int sender_idle_pct = 38;
  int receiver_idle_pct = 47;
  int hold_request = 0;
  int hold_left = 0;
  int sent = 0;
  longint unsigned cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure; a long hold lets the input queue fill up.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    bucket_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.mn = out_tdata[15:0];
      got.mx = out_tdata[30:16];
      got.rms = out_tdata[46:31];
      got.cnt = out_tdata[86:47];
      got.any = out_tuser[0];
      board.check(got);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(abp_pkg::reg_idx_t r, logic [63:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 5'(r) << 3;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    board.set_reg(r, v);
  endtask

  task automatic wait_drained();
    // The last beat was accepted; stop offering it again.
    in_tvalid <= 1'b0;
    while (board.reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [47:0] lo, logic [47:0] hi, logic [10:0] nb,
                           logic [18:0] dr);
    wait_drained();
    write_reg(abp_pkg::REG_WSTART, lo);
    write_reg(abp_pkg::REG_WEND, hi);
    write_reg(abp_pkg::REG_BCOUNT, nb);
    write_reg(abp_pkg::REG_DRATE, dr);
  endtask

  task automatic send_beat(abp_pkg::cmd_t c, logic signed [15:0] s, logic [47:0] fs,
                           logic [15:0] pos, logic [18:0] rt, logic [9:0] bk);
    if (sent < 300) begin
      sender_idle_pct = 38;
      receiver_idle_pct = 47;
    end else if (sent < 600) begin
      sender_idle_pct = 47;
      receiver_idle_pct = 38;
    end else begin
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
    end
    if ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {3'd0, bk, rt, pos, fs, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.accept(c, s, fs, pos, rt, bk);
    sent++;
  endtask

  task automatic random_beats(int n);
    logic [63:0] span, fs64;
    logic [18:0] rt;
    logic [15:0] pos;
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      span = board.win_hi - board.win_lo;
      case ($urandom_range(5))
        0: rt = 19'd0;
        1: rt = 19'd48000;
        2: rt = 19'd384000;
        3: rt = 19'd44100;
        default: rt = 19'($urandom_range(1, 384000));
      endcase
      pos = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(2000));
      if (board.win_hi > board.win_lo) begin
        fs64 = board.win_lo + rand64() % (span + span / 8 + 1);
        if (fs64 >= span / 16) fs64 = fs64 - span / 16;
      end else begin
        fs64 = board.win_lo + $urandom_range(1000);
      end
      if (p < 68)
        send_beat(abp_pkg::CMD_ADD, 16'($urandom), fs64[47:0], pos, rt, 10'($urandom));
      else if (p < 88)
        send_beat(abp_pkg::CMD_READ, 16'($urandom), 48'(rand64()), 16'($urandom),
                  19'($urandom),
                  ($urandom_range(3) == 0) ? 10'($urandom) :
                  10'($urandom_range(board.nbuckets > 1 ? board.nbuckets - 1 : 0)) );
      else if (p < 89)
        send_beat(abp_pkg::CMD_CLEAR, 16'($urandom), 48'(rand64()), 16'($urandom),
                  19'($urandom), 10'($urandom));
      else if (p < 94)
        send_beat(abp_pkg::CMD_NOP, 16'($urandom), 48'(rand64()), 16'($urandom),
                  19'($urandom), 10'($urandom));
      else
        send_beat(abp_pkg::CMD_ADD, 16'($urandom), 48'(rand64()), 16'($urandom),
                  19'($urandom_range(384000)), 10'($urandom));
    end
  endtask

  initial begin
    board.power_on();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window is empty, so every sample is dropped.
    send_beat(abp_pkg::CMD_ADD, 16'sd1000, 48'd0, 16'd0, 19'd0, 10'd0);
    send_beat(abp_pkg::CMD_READ, 16'sd0, 48'd0, 16'd0, 19'd0, 10'd0);
    send_beat(abp_pkg::CMD_NOP, 16'sd5, MAX48, 16'hFFFF, 19'd384000, 10'd1023);
    random_beats(30);

    configure(48'd1000000, 48'd2000000000, 11'd1024, 19'd48000);
    send_beat(abp_pkg::CMD_ADD, -16'sd32768, 48'd1000000, 16'd0, 19'd0, 10'd0);
    send_beat(abp_pkg::CMD_ADD, 16'sd32767, 48'd1000000, 16'd0, 19'd384000, 10'd0);
    send_beat(abp_pkg::CMD_ADD, 16'sd0, 48'd1999999999, 16'd0, 19'd0, 10'd0);
    send_beat(abp_pkg::CMD_ADD, 16'sd77, 48'd2000000000, 16'd0, 19'd0, 10'd0);
    send_beat(abp_pkg::CMD_ADD, 16'sd77, 48'd999999, 16'd0, 19'd0, 10'd0);
    send_beat(abp_pkg::CMD_ADD, -16'sd5, 48'd1000000, 16'hFFFF, 19'd384000, 10'd0);
    send_beat(abp_pkg::CMD_ADD, 16'sd123, 48'd0, 16'hFFFF, 19'd48000, 10'd0);
    send_beat(abp_pkg::CMD_READ, 16'sd0, 48'd0, 16'd0, 19'd0, 10'd0);
    send_beat(abp_pkg::CMD_READ, 16'sd0, 48'd0, 16'd0, 19'd0, 10'd1023);
    send_beat(abp_pkg::CMD_READ, 16'sd0, 48'd0, 16'd0, 19'd0, 10'd87);
    send_beat(abp_pkg::CMD_CLEAR, 16'sd0, 48'd0, 16'd0, 19'd0, 10'd0);
    send_beat(abp_pkg::CMD_READ, 16'sd0, 48'd0, 16'd0, 19'd0, 10'd0);
    random_beats(110);

    configure(MAX48 - 48'd3000000000, MAX48, 11'd2047, 19'd384000);
    random_beats(100);
    // Default rate of zero drops every sample that gives rate zero.
    configure(48'd500000000, 48'd500001000, 11'd1, 19'd0);
    random_beats(90);
    configure(48'd0, 48'd1000000000, 11'd0, 19'd44100);
    random_beats(60);

    configure(48'd123456789, 48'd3123456789, 11'd37, 19'd96000);
    random_beats(20);
    hold_request = 3000;
    random_beats(120);
    configure(48'd10, 48'd5, 11'd7, 19'd8000);
    random_beats(50);
    configure(48'd0, MAX48, 11'd1024, 19'd48000);
    random_beats(80);
    configure(48'd0, 48'd4000000000, 11'd1024, 19'd48000);
    random_beats(150);

    in_tvalid <= 1'b0;
    wait_drained();
    if (board.errors == 0 && board.reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
